### rtl/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// Multimeter LCD frame decoder package
// Shared types, frame constants and the seven-segment lookup.
// ----------------------------------------------------------------------------
package mlfd_pkg;

    // Frame layout and byte markers (high nibble of a received byte).
    localparam logic [3:0] HI_START  = 4'h1;
    localparam logic [3:0] HI_END    = 4'hE;
    localparam int         FRAME_LEN = 14;
    localparam logic [3:0] LAST_IDX  = 4'(FRAME_LEN - 1);
    localparam logic [3:0] FRAME_CNT = 4'(FRAME_LEN);
    localparam logic [3:0] COUNT_SAT = 4'hF;

    // Unit codes.
    localparam logic [1:0] UNIT_AMPS    = 2'd0;
    localparam logic [1:0] UNIT_VOLTS   = 2'd1;
    localparam logic [1:0] UNIT_UNKNOWN = 2'd2;

    // Segment keys, {3-bit group, 4-bit group}, for the digits 0 to 9.
    localparam logic [6:0] SEG_0 = 7'h7D;
    localparam logic [6:0] SEG_1 = 7'h05;
    localparam logic [6:0] SEG_2 = 7'h5B;
    localparam logic [6:0] SEG_3 = 7'h1F;
    localparam logic [6:0] SEG_4 = 7'h27;
    localparam logic [6:0] SEG_5 = 7'h3E;
    localparam logic [6:0] SEG_6 = 7'h7E;
    localparam logic [6:0] SEG_7 = 7'h15;
    localparam logic [6:0] SEG_8 = 7'h7F;
    localparam logic [6:0] SEG_9 = 7'h3F;

    // Decoded content of one closed frame; digits[0] is the most significant.
    typedef struct packed {
        logic [3:0][3:0] digits;
        logic            neg;
        logic [3:0]      scale;
        logic [1:0]      unit;
        logic            err;
    } decode_t;

    // One reading as it leaves the block.
    typedef struct packed {
        logic [13:0] magnitude;
        logic        neg;
        logic [3:0]  scale;
        logic [1:0]  unit;
        logic        err;
    } reading_t;

    // Normalized reading: trailing zero digits are folded into the exponent.
    typedef struct packed {
        logic             zero;
        logic             neg;
        logic [3:0][3:0]  bcd;
        logic signed [4:0] expo;
    } canon_t;

    // Seven-segment lookup; returns {error, digit}. An unknown pattern reads as 0.
    function automatic logic [4:0] seg_digit(input logic [2:0] a, input logic [3:0] b);
        logic [6:0] key;
        logic [4:0] res;
        key = {a, b};
        case (key)
            SEG_0:   res = {1'b0, 4'd0};
            SEG_1:   res = {1'b0, 4'd1};
            SEG_2:   res = {1'b0, 4'd2};
            SEG_3:   res = {1'b0, 4'd3};
            SEG_4:   res = {1'b0, 4'd4};
            SEG_5:   res = {1'b0, 4'd5};
            SEG_6:   res = {1'b0, 4'd6};
            SEG_7:   res = {1'b0, 4'd7};
            SEG_8:   res = {1'b0, 4'd8};
            SEG_9:   res = {1'b0, 4'd9};
            default: res = {1'b1, 4'd0};
        endcase
        return res;
    endfunction

endpackage

### rtl/multimeter_lcd_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// Multimeter LCD frame decoder core
// Decodes 14-byte LCD segment frames into readings and reports changes.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle on the slave stream whenever the skid
// entry of the result buffer is free. A byte with high nibble 1 starts a
// frame and a byte with high nibble E ends it; a frame of exactly 14 bytes is
// decoded in the cycle its end byte is taken, and its reading is registered and
// presented on the master stream if its value (sign, digits and decimal
// scale, compared as an exact decimal number) differs from the last reading
// reported. The first frame is compared against minus one. A change of unit
// alone is not reported. Unknown segment patterns read as 0 and set the
// error flag. Throughput is one byte per cycle while not stalled; the result
// buffer holds two readings; the input stalls only when two wait downstream.
// ----------------------------------------------------------------------------
module multimeter_lcd_frame_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [13:0] reading_magnitude, [14] negative,
                                   // [18:15] decimal_scale, [23:19] zero
    output logic [2:0]  m_tuser    // [1:0] unit_code, [2] digit_error
);
    import mlfd_pkg::*;

    logic     accept;
    logic     close;
    logic     emit;
    decode_t  decoded;
    reading_t reading;
    reading_t out_data;

    assign accept = s_tvalid && s_tready;

    // Frame collection and segment decode.
    mlfd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_tdata),
        .close   (close),
        .decoded (decoded)
    );

    // Change test against the last reported reading.
    mlfd_change u_change (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (accept && close),
        .decoded (decoded),
        .emit    (emit),
        .reading (reading)
    );

    // Result register with skid entry.
    mlfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (reading),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {5'd0, out_data.scale, out_data.neg, out_data.magnitude};
    assign m_tuser = {out_data.err, out_data.unit};

endmodule

### rtl/mlfd_frame.sv
// ----------------------------------------------------------------------------
// Multimeter LCD frame store
// Collects the low nibbles of a frame, tracks its length and decodes the
// stored segment map when an end byte closes a frame of full length.
// ----------------------------------------------------------------------------
module mlfd_frame (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output logic                close,
    output mlfd_pkg::decode_t   decoded
);
    import mlfd_pkg::*;

    logic [3:0] nib_reg [FRAME_LEN];
    logic [3:0] byte_count_reg;
    logic [3:0] byte_count_next;
    logic [3:0] cnt_base;
    logic [4:0] dig [4];

    // A start byte restarts the count before the byte is placed.
    always_comb begin
        cnt_base = (rx_byte[7:4] == HI_START) ? 4'd0 : byte_count_reg;
        byte_count_next = (cnt_base < COUNT_SAT) ? cnt_base + 4'd1 : cnt_base;
        close = (rx_byte[7:4] == HI_END) && (byte_count_next == FRAME_CNT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 4'd0;
        end else if (accept) begin
            byte_count_reg <= byte_count_next;
        end
    end

    // Nibble store; bytes past the end of a frame are dropped.
    always_ff @(posedge aclk) begin
        if (accept && (cnt_base <= LAST_IDX)) begin
            nib_reg[cnt_base] <= rx_byte[3:0];
        end
    end

    // Segment decode of the stored frame. The closing byte lands in the last
    // slot, which the decode never reads, so only stored nibbles are used.
    always_comb begin
        logic err_any;
        err_any = 1'b0;
        for (int i = 0; i < 4; i++) begin
            dig[i] = seg_digit(nib_reg[1 + 2 * i][2:0], nib_reg[2 + 2 * i]);
            decoded.digits[i] = dig[i][3:0];
            err_any = err_any | dig[i][4];
        end
        decoded.err = err_any;
        decoded.neg = nib_reg[1][3];
        decoded.scale = (nib_reg[3][3]  ? 4'd3 : 4'd0) + (nib_reg[5][3] ? 4'd2 : 4'd0)
                      + (nib_reg[7][3]  ? 4'd1 : 4'd0) + (nib_reg[10][3] ? 4'd3 : 4'd0)
                      + (nib_reg[9][3]  ? 4'd3 : 4'd0);
        if (nib_reg[12][3]) begin
            decoded.unit = UNIT_AMPS;
        end else if (nib_reg[12][2]) begin
            decoded.unit = UNIT_VOLTS;
        end else begin
            decoded.unit = UNIT_UNKNOWN;
        end
    end

endmodule

### rtl/mlfd_change.sv
// ----------------------------------------------------------------------------
// Multimeter LCD reading change detector
// Normalizes each decoded reading, compares it with the last reported one
// and flags a result only when the value differs.
// ----------------------------------------------------------------------------
module mlfd_change (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  mlfd_pkg::decode_t   decoded,
    output logic                emit,
    output mlfd_pkg::reading_t  reading
);
    import mlfd_pkg::*;

    canon_t last_reg;
    canon_t cur;
    logic   same;

    // Strip trailing zero digits so that equal values have one form.
    always_comb begin
        logic [3:0][3:0] d;
        d = decoded.digits;
        cur.neg = decoded.neg;
        cur.zero = (d[0] == 4'd0) && (d[1] == 4'd0) && (d[2] == 4'd0) && (d[3] == 4'd0);
        if (d[3] != 4'd0) begin
            cur.bcd  = {d[0], d[1], d[2], d[3]};
            cur.expo = $signed({1'b0, decoded.scale});
        end else if (d[2] != 4'd0) begin
            cur.bcd  = {4'd0, d[0], d[1], d[2]};
            cur.expo = $signed({1'b0, decoded.scale}) - 5'sd1;
        end else if (d[1] != 4'd0) begin
            cur.bcd  = {4'd0, 4'd0, d[0], d[1]};
            cur.expo = $signed({1'b0, decoded.scale}) - 5'sd2;
        end else begin
            cur.bcd  = {4'd0, 4'd0, 4'd0, d[0]};
            cur.expo = $signed({1'b0, decoded.scale}) - 5'sd3;
        end
    end

    // Zero equals zero whatever the sign or scale.
    always_comb begin
        if (cur.zero || last_reg.zero) begin
            same = cur.zero && last_reg.zero;
        end else begin
            same = (cur.neg == last_reg.neg) && (cur.bcd == last_reg.bcd)
                && (cur.expo == last_reg.expo);
        end
        emit = fire && !same;
    end

    // The reading before the first report is minus one at scale zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg.zero <= 1'b0;
            last_reg.neg  <= 1'b1;
            last_reg.bcd  <= 16'h0001;
            last_reg.expo <= 5'sd0;
        end else if (emit) begin
            last_reg <= cur;
        end
    end

    // Binary magnitude and the remaining result fields.
    always_comb begin
        reading.magnitude = 14'(decoded.digits[0]) * 14'd1000
                          + 14'(decoded.digits[1]) * 14'd100
                          + 14'(decoded.digits[2]) * 14'd10
                          + 14'(decoded.digits[3]);
        reading.neg   = decoded.neg;
        reading.scale = decoded.scale;
        reading.unit  = decoded.unit;
        reading.err   = decoded.err;
    end

endmodule

### rtl/mlfd_out_buf.sv
// ----------------------------------------------------------------------------
// Multimeter LCD result buffer
// Output register with a skid entry, so the input side keeps running while a
// result waits for the downstream side.
// ----------------------------------------------------------------------------
module mlfd_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mlfd_pkg::reading_t  push_data,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mlfd_pkg::reading_t  out_data
);
    import mlfd_pkg::*;

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    reading_t main_reg, main_next;
    reading_t skid_reg, skid_next;

    // New requests are taken while the skid entry is free.
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            // The output slot frees up: refill it from the skid entry first.
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
